@@ hw/rtl/voxel_chunk_stream_parser_defines.svh @@
// Assertion macros for the voxel chunk stream parser
`ifndef VOXEL_CHUNK_STREAM_PARSER_DEFINES_SVH
`define VOXEL_CHUNK_STREAM_PARSER_DEFINES_SVH

`define VCSP_ASSERT_NOW(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("vcsp assertion failed");

`define VCSP_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("vcsp assertion failed");

`endif

@@ hw/rtl/vcsp_pkg.sv @@
// Shared types and constants for the voxel chunk stream parser
package vcsp_pkg;

   localparam logic [1:0] KIND_VOXEL   = 2'd0;
   localparam logic [1:0] KIND_PALETTE = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   localparam logic [3:0] ERR_TRUNC     = 4'd0;
   localparam logic [3:0] ERR_MAGIC     = 4'd1;
   localparam logic [3:0] ERR_NO_MAIN   = 4'd2;
   localparam logic [3:0] ERR_SIZE      = 4'd3;
   localparam logic [3:0] ERR_PACK      = 4'd4;
   localparam logic [3:0] ERR_DUP_SIZE  = 4'd5;
   localparam logic [3:0] ERR_DIM       = 4'd6;
   localparam logic [3:0] ERR_DUP_XYZI  = 4'd7;
   localparam logic [3:0] ERR_COLOR0    = 4'd8;
   localparam logic [3:0] ERR_DUP_RGBA  = 4'd9;
   localparam logic [3:0] ERR_RGBA_LEN  = 4'd10;
   localparam logic [3:0] ERR_NO_SIZE   = 4'd11;
   localparam logic [3:0] ERR_NO_XYZI   = 4'd12;
   localparam logic [3:0] ERR_NO_RGBA   = 4'd13;
   localparam logic [3:0] ERR_BOUNDS    = 4'd14;

   localparam logic [31:0] TAG_VOX  = 32'h20584F56;
   localparam logic [31:0] TAG_MAIN = 32'h4E49414D;
   localparam logic [31:0] TAG_PACK = 32'h4B434150;
   localparam logic [31:0] TAG_SIZE = 32'h455A4953;
   localparam logic [31:0] TAG_XYZI = 32'h495A5958;
   localparam logic [31:0] TAG_RGBA = 32'h41424752;

   localparam logic [31:0] RGBA_BYTES = 32'd1024;
   localparam logic [7:0]  LAST_SLOT  = 8'd255;
   localparam logic [8:0]  RES_RESET  = 9'd32;

   typedef enum logic [18:0] {
      PH_MAGIC      = 19'h00001,
      PH_VERSION    = 19'h00002,
      PH_MAIN_ID    = 19'h00004,
      PH_MAIN_CSIZE = 19'h00008,
      PH_MAIN_KSIZE = 19'h00010,
      PH_MAIN_SKIP  = 19'h00020,
      PH_HDR_ID     = 19'h00040,
      PH_HDR_CSIZE  = 19'h00080,
      PH_HDR_KSIZE  = 19'h00100,
      PH_PACK       = 19'h00200,
      PH_SIZE_X     = 19'h00400,
      PH_SIZE_Y     = 19'h00800,
      PH_SIZE_Z     = 19'h01000,
      PH_XYZI_COUNT = 19'h02000,
      PH_VOXEL      = 19'h04000,
      PH_RGBA       = 19'h08000,
      PH_SKIP       = 19'h10000,
      PH_DONE       = 19'h20000,
      PH_FAIL       = 19'h40000
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  z;
      logic [7:0]  ci;
      logic [31:0] rgba;
      logic [3:0]  err;
      logic        last;
   } rec_type;

endpackage

@@ hw/rtl/vcsp_core.sv @@
// Byte-wise chunk walker: parser state and up to two result records per byte
module vcsp_core import vcsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   input  logic [8:0] resolution,
   output logic [1:0] res_valid,
   output rec_type    res0,
   output rec_type    res1
);

   typedef struct packed {
      phase_type  ph;
      logic       bad;
      logic [3:0] code;
   } nxt_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] off_ff, off_in;
   logic [31:0] mce_ff, mce_in;
   logic [31:0] cce_ff, cce_in;
   logic [31:0] ce_ff, ce_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] items_ff, items_in;
   logic [7:0]  slot_ff, slot_in;
   logic [2:0]  seen_ff, seen_in;
   logic        err_ff, err_in;
   logic [3:0]  code_ff, code_in;

   function automatic nxt_type next_child_f(logic [31:0] off, logic [31:0] mce,
                                            logic [2:0] seen);
      nxt_type r;
      r = '{ph: PH_HDR_ID, bad: 1'b0, code: ERR_TRUNC};
      if (off >= mce) begin
         if (!seen[0])      r = '{ph: PH_FAIL, bad: 1'b1, code: ERR_NO_SIZE};
         else if (!seen[1]) r = '{ph: PH_FAIL, bad: 1'b1, code: ERR_NO_XYZI};
         else if (!seen[2]) r = '{ph: PH_FAIL, bad: 1'b1, code: ERR_NO_RGBA};
         else               r = '{ph: PH_DONE, bad: 1'b0, code: ERR_TRUNC};
      end
      return r;
   endfunction

   function automatic nxt_type finish_f(logic [31:0] off, logic [31:0] ce,
                                        logic [31:0] mce, logic [2:0] seen);
      nxt_type r;
      r = '{ph: PH_SKIP, bad: 1'b0, code: ERR_TRUNC};
      if (off >= ce) r = next_child_f(off, mce, seen);
      return r;
   endfunction

   always_comb begin
      logic        collect;
      logic        full;
      logic        act;
      nxt_type     nx;
      logic [32:0] cend;
      logic [32:0] cend2;
      logic [33:0] need;
      logic [31:0] avail;
      logic [31:0] rgba;
      logic [3:0]  early;

      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      word_in  = word_ff;
      mce_in   = mce_ff;
      cce_in   = cce_ff;
      ce_in    = ce_ff;
      tag_in   = tag_ff;
      items_in = items_ff;
      slot_in  = slot_ff;
      seen_in  = seen_ff;
      err_in   = err_ff;
      code_in  = code_ff;
      res_valid = 2'b00;
      res0 = '0;
      res1 = '0;
      act  = 1'b0;
      nx   = '{ph: phase_ff, bad: 1'b0, code: ERR_TRUNC};
      cend = '0;
      cend2 = '0;
      need = '0;
      avail = '0;
      rgba = '0;
      early = ERR_TRUNC;

      off_in = (off_ff != 32'hFFFF_FFFF) ? off_ff + 32'd1 : off_ff;

      collect = !(phase_ff == PH_DONE || phase_ff == PH_FAIL ||
                  phase_ff == PH_SKIP || phase_ff == PH_MAIN_SKIP);
      full = collect && (cnt_ff == 2'd3);
      if (collect) begin
         word_in = word_ff | ({24'd0, data_byte} << {cnt_ff, 3'b000});
         cnt_in  = cnt_ff + 2'd1;
      end

      case (phase_ff)
         PH_MAGIC: begin
            if (full) begin
               tag_in = word_in;
               nx = '{ph: PH_VERSION, bad: 1'b0, code: ERR_TRUNC}; act = 1'b1;
            end
         end
         PH_VERSION: begin
            if (full) begin
               act = 1'b1;
               if (tag_ff != TAG_VOX) nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_MAGIC};
               else nx = '{ph: PH_MAIN_ID, bad: 1'b0, code: ERR_TRUNC};
            end
         end
         PH_MAIN_ID: begin
            if (full) begin
               tag_in = word_in;
               nx = '{ph: PH_MAIN_CSIZE, bad: 1'b0, code: ERR_TRUNC}; act = 1'b1;
            end
         end
         PH_MAIN_CSIZE: begin
            if (full) begin
               cce_in = word_in;
               nx = '{ph: PH_MAIN_KSIZE, bad: 1'b0, code: ERR_TRUNC}; act = 1'b1;
            end
         end
         PH_MAIN_KSIZE: begin
            if (full) begin
               act = 1'b1;
               cend  = {1'b0, off_in} + {1'b0, cce_ff};
               cend2 = cend + {1'b0, word_in};
               if (tag_ff != TAG_MAIN) begin
                  nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_NO_MAIN};
               end else if (cce_ff[31] || word_in[31] || cend2[32]) begin
                  nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_SIZE};
               end else begin
                  cce_in = cend[31:0];
                  mce_in = cend2[31:0];
                  if (cce_ff == 32'd0) nx = next_child_f(off_in, mce_in, seen_ff);
                  else nx = '{ph: PH_MAIN_SKIP, bad: 1'b0, code: ERR_TRUNC};
               end
            end
         end
         PH_MAIN_SKIP: begin
            if (off_in >= cce_ff) begin
               act = 1'b1;
               nx = next_child_f(off_in, mce_ff, seen_ff);
            end
         end
         PH_HDR_ID: begin
            if (full) begin
               tag_in = word_in;
               nx = '{ph: PH_HDR_CSIZE, bad: 1'b0, code: ERR_TRUNC}; act = 1'b1;
            end
         end
         PH_HDR_CSIZE: begin
            if (full) begin
               cce_in = word_in;
               nx = '{ph: PH_HDR_KSIZE, bad: 1'b0, code: ERR_TRUNC}; act = 1'b1;
            end
         end
         PH_HDR_KSIZE: begin
            if (full) begin
               act = 1'b1;
               cend  = {1'b0, off_in} + {1'b0, cce_ff};
               cend2 = cend + {1'b0, word_in};
               if (cce_ff[31] || word_in[31] || cend2 > {1'b0, mce_ff}) begin
                  nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_SIZE};
               end else begin
                  cce_in = cend[31:0];
                  ce_in  = cend2[31:0];
                  if (tag_ff == TAG_PACK) begin
                     if (cce_ff < 32'd4) nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_SIZE};
                     else nx = '{ph: PH_PACK, bad: 1'b0, code: ERR_TRUNC};
                  end else if (tag_ff == TAG_SIZE) begin
                     if (seen_ff[0]) nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_DUP_SIZE};
                     else if (cce_ff < 32'd12)
                        nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_SIZE};
                     else begin
                        items_in = '0;
                        nx = '{ph: PH_SIZE_X, bad: 1'b0, code: ERR_TRUNC};
                     end
                  end else if (tag_ff == TAG_XYZI) begin
                     if (seen_ff[1]) nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_DUP_XYZI};
                     else if (cce_ff < 32'd4) nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_SIZE};
                     else nx = '{ph: PH_XYZI_COUNT, bad: 1'b0, code: ERR_TRUNC};
                  end else if (tag_ff == TAG_RGBA) begin
                     if (seen_ff[2]) nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_DUP_RGBA};
                     else if (cce_ff != RGBA_BYTES)
                        nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_RGBA_LEN};
                     else begin
                        seen_in[2] = 1'b1;
                        slot_in = '0;
                        nx = '{ph: PH_RGBA, bad: 1'b0, code: ERR_TRUNC};
                     end
                  end else begin
                     nx = finish_f(off_in, ce_in, mce_ff, seen_ff);
                  end
               end
            end
         end
         PH_PACK: begin
            if (full) begin
               act = 1'b1;
               if (word_in != 32'd1) nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_PACK};
               else nx = finish_f(off_in, ce_ff, mce_ff, seen_ff);
            end
         end
         PH_SIZE_X, PH_SIZE_Y, PH_SIZE_Z: begin
            if (full) begin
               act = 1'b1;
               if (word_in != {23'd0, resolution}) items_in = 32'd1;
               if (phase_ff == PH_SIZE_Z) begin
                  if (items_in != 32'd0) nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_DIM};
                  else begin
                     seen_in[0] = 1'b1;
                     nx = finish_f(off_in, ce_ff, mce_ff, seen_in);
                  end
               end else if (phase_ff == PH_SIZE_X) begin
                  nx = '{ph: PH_SIZE_Y, bad: 1'b0, code: ERR_TRUNC};
               end else begin
                  nx = '{ph: PH_SIZE_Z, bad: 1'b0, code: ERR_TRUNC};
               end
            end
         end
         PH_XYZI_COUNT: begin
            if (full) begin
               act = 1'b1;
               need  = {word_in, 2'b00} + 34'd4;
               avail = cce_ff - (off_in - 32'd4);
               if (word_in[31] || need > {2'b00, avail}) begin
                  nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_SIZE};
               end else begin
                  seen_in[1] = 1'b1;
                  items_in = word_in;
                  if (word_in == 32'd0) nx = finish_f(off_in, ce_ff, mce_ff, seen_in);
                  else nx = '{ph: PH_VOXEL, bad: 1'b0, code: ERR_TRUNC};
               end
            end
         end
         PH_VOXEL: begin
            if (full) begin
               act = 1'b1;
               if (word_in[31:24] == 8'd0) begin
                  nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_COLOR0};
               end else if ({1'b0, word_in[7:0]} >= resolution ||
                            {1'b0, word_in[15:8]} >= resolution ||
                            {1'b0, word_in[23:16]} >= resolution) begin
                  nx = '{ph: PH_FAIL, bad: 1'b1, code: ERR_BOUNDS};
               end else begin
                  res_valid[0] = 1'b1;
                  res0.kind = KIND_VOXEL;
                  res0.x  = word_in[7:0];
                  res0.y  = word_in[15:8];
                  res0.z  = word_in[23:16];
                  res0.ci = word_in[31:24];
                  items_in = items_ff - 32'd1;
                  if (items_in == 32'd0) nx = finish_f(off_in, ce_ff, mce_ff, seen_ff);
                  else nx = '{ph: PH_VOXEL, bad: 1'b0, code: ERR_TRUNC};
               end
            end
         end
         PH_RGBA: begin
            if (full) begin
               act = 1'b1;
               rgba = {word_in[7:0], word_in[15:8], word_in[23:16], word_in[31:24]};
               if (slot_ff != LAST_SLOT) begin
                  res_valid[0] = 1'b1;
                  res0.kind = KIND_PALETTE;
                  res0.ci   = slot_ff + 8'd1;
                  res0.rgba = rgba;
                  slot_in = slot_ff + 8'd1;
                  nx = '{ph: PH_RGBA, bad: 1'b0, code: ERR_TRUNC};
               end else begin
                  nx = finish_f(off_in, ce_ff, mce_ff, seen_ff);
               end
            end
         end
         PH_SKIP: begin
            if (off_in >= ce_ff) begin
               act = 1'b1;
               nx = next_child_f(off_in, mce_ff, seen_ff);
            end
         end
         default: begin
         end
      endcase

      if (act) begin
         phase_in = nx.ph;
         cnt_in   = '0;
         word_in  = '0;
         if (nx.bad && !err_ff) begin
            err_in  = 1'b1;
            code_in = nx.code;
         end
      end

      if (last_byte) begin
         case (phase_in)
            PH_MAGIC, PH_VERSION: early = ERR_TRUNC;
            PH_MAIN_ID, PH_MAIN_CSIZE, PH_MAIN_KSIZE: early = ERR_NO_MAIN;
            PH_MAIN_SKIP: early = ERR_SIZE;
            default: early = (off_in < mce_in) ? ERR_SIZE : ERR_TRUNC;
         endcase
         res_valid[1] = 1'b1;
         res1.last = 1'b1;
         if (err_in) begin
            res1.kind = KIND_ERROR;
            res1.err  = code_in;
         end else if (phase_in == PH_DONE) begin
            res1.kind = KIND_DONE;
         end else begin
            res1.kind = KIND_ERROR;
            res1.err  = early;
         end
      end else begin
         res0.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         phase_ff <= PH_MAGIC;
         cnt_ff   <= '0;
         word_ff  <= '0;
         off_ff   <= '0;
         mce_ff   <= '0;
         cce_ff   <= '0;
         ce_ff    <= '0;
         tag_ff   <= '0;
         items_ff <= '0;
         slot_ff  <= '0;
         seen_ff  <= '0;
         err_ff   <= 1'b0;
         code_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         word_ff  <= word_in;
         off_ff   <= off_in;
         mce_ff   <= mce_in;
         cce_ff   <= cce_in;
         ce_ff    <= ce_in;
         tag_ff   <= tag_in;
         items_ff <= items_in;
         slot_ff  <= slot_in;
         seen_ff  <= seen_in;
         err_ff   <= err_in;
         code_ff  <= code_in;
      end
   end

endmodule

@@ hw/rtl/voxel_chunk_stream_parser.sv @@
// Top level: csr register, parser core and result queue
//
// Input channel req_: one file byte per beat (req_data_byte) with
// req_last_byte on the final byte of the file. Result channel rsp_: voxel
// records, palette entries and a final verdict (accepted or error code),
// rsp_last_of_run marks the last result caused by one input byte.
// Configuration channel csr_: write csr_resolution while no file is in flight;
// it is always ready.
// Each byte is parsed in the cycle it is accepted; its results (at most two)
// are registered into a four-entry result queue and appear on rsp_ in order.
// Throughput: one byte per cycle while the receiver takes one result per cycle.
// req_ready drops when fewer than two queue entries are free, so a stalled
// receiver backs the stream up after at most four pending results.
// After the last byte the parser clears itself for the next file.
// Reset (synchronous, active high) empties the queue, restarts parsing at
// the magic and sets resolution to 32.
module voxel_chunk_stream_parser import vcsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_voxel_x,
   output logic [7:0]  rsp_voxel_y,
   output logic [7:0]  rsp_voxel_z,
   output logic [7:0]  rsp_color_index,
   output logic [31:0] rsp_rgba_word,
   output logic [3:0]  rsp_error_code,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_resolution
);
`include "voxel_chunk_stream_parser_defines.svh"

   logic [8:0] res_ff;
   logic       step;
   logic [1:0] res_valid;
   rec_type    res0, res1;
   rec_type    q_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;
   rec_type    head;

   assign csr_ready = 1'b1;
   assign req_ready = (cnt_ff <= 3'd2);
   assign step = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= RES_RESET;
      end else if (csr_valid) begin
         res_ff <= csr_resolution;
      end
   end

   vcsp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .resolution (res_ff),
      .res_valid  (res_valid),
      .res0       (res0),
      .res1       (res1)
   );

   assign pop = rsp_valid && rsp_ready;

   always_comb begin
      wr_in  = wr_ff;
      cnt_in = cnt_ff;
      if (step) begin
         wr_in  = wr_ff + {1'b0, res_valid[0]} + {1'b0, res_valid[1]};
         cnt_in = cnt_ff + {2'b00, res_valid[0]} + {2'b00, res_valid[1]};
      end
      if (pop) cnt_in = cnt_in - 3'd1;
      rd_in = pop ? rd_ff + 2'd1 : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         if (res_valid[0]) begin
            q_ff[wr_ff] <= res0;
            if (res_valid[1]) q_ff[wr_ff + 2'd1] <= res1;
         end else if (res_valid[1]) begin
            q_ff[wr_ff] <= res1;
         end
      end
   end

   assign head            = q_ff[rd_ff];
   assign rsp_valid       = (cnt_ff != 3'd0);
   assign rsp_kind        = head.kind;
   assign rsp_voxel_x     = head.x;
   assign rsp_voxel_y     = head.y;
   assign rsp_voxel_z     = head.z;
   assign rsp_color_index = head.ci;
   assign rsp_rgba_word   = head.rgba;
   assign rsp_error_code  = head.err;
   assign rsp_last_of_run = head.last;

   `VCSP_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, cnt_ff <= 3'd4)
   `VCSP_ASSERT_NEXT(a_last_gives_result, clock, reset, step && req_last_byte, rsp_valid)
   `VCSP_ASSERT_NOW(a_ready_room, clock, reset, req_ready, cnt_ff <= 3'd2)

endmodule
